// File: rtl/core/sfra_pkg.sv
`timescale 1ns / 1ps

package sfra_pkg;

    // Default width of the anti-replay window in sequence numbers.
    localparam int WINDOW_BITS_DEF = 64;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 16;
    localparam int FRAG_W = 8;
    localparam int CTRL_W = 4;
    localparam int CLS_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 4;

    localparam logic [SEQ_W-1:0] SEQ_TERMINAL = 32'hFFFF_FFFF;
    localparam logic [LEN_W-1:0] OVERHEAD     = 16'd28;
    localparam logic [LEN_W-1:0] CTRL_ROOM    = 16'd32;
    localparam logic [LEN_W-1:0] REKEY_SALT   = 16'd32;

    localparam logic              RST_DGRAM     = 1'b1;
    localparam logic [LEN_W-1:0]  RST_BUF_LIMIT = 16'd4096;
    localparam logic [FRAG_W-1:0] RST_MAX_FRAG  = 8'd16;
    localparam logic [CTRL_W-1:0] RST_MAX_CTRL  = 4'd8;

    localparam logic [CLS_W-1:0] CLS_DATA  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_FRAG  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_PING  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_PONG  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BYE   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_REKEY = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DGRAM     = 2'd0,
        REG_BUF_LIMIT = 2'd1,
        REG_MAX_FRAG  = 2'd2,
        REG_MAX_CTRL  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        VERD_FRAG   = 4'd0,
        VERD_DONE   = 4'd1,
        VERD_PONG   = 4'd2,
        VERD_PING   = 4'd3,
        VERD_REKEY  = 4'd4,
        VERD_DROP   = 4'd5,
        VERD_ERROR  = 4'd6,
        VERD_CLOSED = 4'd7,
        VERD_NOCONN = 4'd8
    } t_verdict;

    typedef struct packed {
        logic              dgram;
        logic [LEN_W-1:0]  buf_limit;
        logic [FRAG_W-1:0] max_frag;
        logic [CTRL_W-1:0] max_ctrl;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [CLS_W-1:0]  cls;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  plen;
        logic              pok;
        logic              aok;
    } t_item;

    typedef struct packed {
        logic              open;
        logic [SEQ_W-1:0]  hseq;
        logic [LEN_W-1:0]  rbytes;
        logic [FRAG_W-1:0] fcount;
        logic [SEQ_W-1:0]  efseq;
        logic [CTRL_W-1:0] ccount;
    } t_sess;

    typedef struct packed {
        t_verdict          verdict;
        logic [LEN_W-1:0]  msg_len;
        logic [LEN_W-1:0]  plain_bytes;
        logic              up;
        logic [SEQ_W-1:0]  top;
    } t_res;

endpackage

// File: rtl/core/sfra_window.sv
`timescale 1ns / 1ps

// Sliding anti-replay window: stale/duplicate check and the updated bitmap
// for a frame that is admitted.
module sfra_window #(
    parameter int WINDOW_BITS = sfra_pkg::WINDOW_BITS_DEF
) (
    input  logic [sfra_pkg::SEQ_W-1:0] i_hseq,
    input  logic [sfra_pkg::SEQ_W-1:0] i_seq,
    input  logic [WINDOW_BITS-1:0]     i_bitmap,
    output logic                       o_stale,
    output logic                       o_newer,
    output logic [WINDOW_BITS-1:0]     o_bitmap_n
);

    localparam int IW = $clog2(WINDOW_BITS);
    localparam logic [sfra_pkg::SEQ_W-1:0] WIN = sfra_pkg::SEQ_W'(WINDOW_BITS);
    localparam logic [WINDOW_BITS-1:0] ONE = WINDOW_BITS'(1);

    logic [sfra_pkg::SEQ_W-1:0] w_off;
    logic [sfra_pkg::SEQ_W-1:0] w_sh;
    logic                       w_too_old;
    logic                       w_dup;

    assign w_off = i_hseq - i_seq;
    assign w_sh  = i_seq - i_hseq;

    assign w_too_old = (i_hseq >= WIN) && (i_seq <= (i_hseq - WIN));
    assign o_newer   = i_seq > i_hseq;
    assign w_dup     = !w_too_old && !o_newer && i_bitmap[w_off[IW-1:0]];
    assign o_stale   = w_too_old || w_dup;

    always_comb begin
        if (o_newer) begin
            if (w_sh < WIN) begin
                o_bitmap_n = (i_bitmap << w_sh[IW-1:0]) | ONE;
            end else begin
                o_bitmap_n = ONE;
            end
        end else begin
            o_bitmap_n = i_bitmap | (ONE << w_off[IW-1:0]);
        end
    end

endmodule

// File: rtl/core/sfra_judge.sv
`timescale 1ns / 1ps

// Admission decision for one registered frame header, with the next session
// state and the result beat.
module sfra_judge #(
    parameter int WINDOW_BITS = sfra_pkg::WINDOW_BITS_DEF
) (
    input  sfra_pkg::t_cfg         i_cfg,
    input  sfra_pkg::t_item        i_item,
    input  sfra_pkg::t_sess        i_sess,
    input  logic [WINDOW_BITS-1:0] i_bitmap,
    output sfra_pkg::t_sess        o_sess_n,
    output logic [WINDOW_BITS-1:0] o_bitmap_n,
    output sfra_pkg::t_res         o_res
);

    logic                   w_stale;
    logic                   w_newer;
    logic [WINDOW_BITS-1:0] w_bitmap_adm;

    sfra_window #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_window (
        .i_hseq    (i_sess.hseq),
        .i_seq     (i_item.seq),
        .i_bitmap  (i_bitmap),
        .o_stale   (w_stale),
        .o_newer   (w_newer),
        .o_bitmap_n(w_bitmap_adm)
    );

    always_comb begin
        sfra_pkg::t_sess                n;
        logic [WINDOW_BITS-1:0]         bm;
        sfra_pkg::t_verdict             v;
        logic [sfra_pkg::LEN_W-1:0]     msg;
        logic [sfra_pkg::LEN_W-1:0]     plain;
        logic [sfra_pkg::LEN_W-1:0]     room;
        logic [sfra_pkg::LEN_W-1:0]     sum;
        logic [sfra_pkg::FRAG_W-1:0]    fc1;
        logic [sfra_pkg::CTRL_W:0]      cnext;
        logic                           is_ctrl;
        logic                           is_data;
        logic                           fault_f;
        logic                           fail_f;
        logic                           seq_ok;

        n       = i_sess;
        bm      = i_bitmap;
        v       = sfra_pkg::VERD_FRAG;
        msg     = '0;
        fault_f = 1'b0;
        fail_f  = 1'b0;
        seq_ok  = 1'b1;
        is_ctrl = (i_item.cls >= sfra_pkg::CLS_PING) && (i_item.cls <= sfra_pkg::CLS_REKEY);
        is_data = (i_item.cls == sfra_pkg::CLS_DATA) || (i_item.cls == sfra_pkg::CLS_FRAG);
        plain   = (i_item.plen >= sfra_pkg::OVERHEAD) ? (i_item.plen - sfra_pkg::OVERHEAD)
                                                       : '0;
        room    = is_ctrl ? sfra_pkg::CTRL_ROOM : (i_cfg.buf_limit - i_sess.rbytes);
        sum     = i_sess.rbytes + plain;
        fc1     = i_sess.fcount + 8'd1;
        cnext   = {1'b0, i_sess.ccount} + 5'd1;

        if (i_item.op) begin
            n      = '0;
            n.open = 1'b1;
            bm     = '0;
            plain  = '0;
        end else if (!i_sess.open) begin
            v = sfra_pkg::VERD_NOCONN;
        end else if (!i_item.pok) begin
            fault_f = 1'b1;
        end else if (i_cfg.dgram && (i_item.seq == sfra_pkg::SEQ_TERMINAL)) begin
            n.open = 1'b0;
            fail_f = 1'b1;
        end else if (i_cfg.dgram && w_stale) begin
            v = sfra_pkg::VERD_DROP;
        end else if (is_ctrl && (i_sess.rbytes != '0)) begin
            fault_f = 1'b1;
        end else if (is_data && (i_cfg.buf_limit < i_sess.rbytes)) begin
            fail_f = 1'b1;
        end else if (!is_ctrl && !is_data) begin
            fault_f = 1'b1;
        end else if (i_item.plen < sfra_pkg::OVERHEAD) begin
            fault_f = 1'b1;
        end else if (plain > room) begin
            fault_f = 1'b1;
        end else if (!i_item.aok) begin
            fault_f = 1'b1;
        end else begin
            // Sequence rules: window admission or strict in-order stream.
            if (i_cfg.dgram) begin
                bm = w_bitmap_adm;
                if (w_newer) begin
                    n.hseq = i_item.seq;
                end
            end else if (i_sess.hseq == sfra_pkg::SEQ_TERMINAL) begin
                n.open = 1'b0;
                fail_f = 1'b1;
                seq_ok = 1'b0;
            end else if (i_item.seq != i_sess.hseq) begin
                fail_f = 1'b1;
                seq_ok = 1'b0;
            end else begin
                n.hseq = i_sess.hseq + 32'd1;
            end

            if (seq_ok) begin
                case (i_item.cls)
                    sfra_pkg::CLS_PING, sfra_pkg::CLS_PONG: begin
                        if (cnext > {1'b0, i_cfg.max_ctrl}) begin
                            fail_f = 1'b1;
                        end else begin
                            n.ccount = cnext[sfra_pkg::CTRL_W-1:0];
                            v = (i_item.cls == sfra_pkg::CLS_PONG) ? sfra_pkg::VERD_PONG
                                                                   : sfra_pkg::VERD_PING;
                        end
                    end
                    sfra_pkg::CLS_BYE: begin
                        n.open   = 1'b0;
                        n.rbytes = '0;
                        n.fcount = '0;
                        n.ccount = '0;
                        v        = sfra_pkg::VERD_CLOSED;
                    end
                    sfra_pkg::CLS_REKEY: begin
                        if (plain != sfra_pkg::REKEY_SALT) begin
                            fail_f = 1'b1;
                        end else begin
                            n.hseq = '0;
                            bm     = '0;
                            if (cnext > {1'b0, i_cfg.max_ctrl}) begin
                                fail_f = 1'b1;
                            end else begin
                                n.ccount = cnext[sfra_pkg::CTRL_W-1:0];
                                v        = sfra_pkg::VERD_REKEY;
                            end
                        end
                    end
                    default: begin
                        // Data and data fragments: reassembly.
                        if ((i_sess.fcount != '0) && (i_item.seq != i_sess.efseq)) begin
                            fail_f = 1'b1;
                        end else begin
                            n.efseq = (i_sess.fcount != '0) ? (i_sess.efseq + 32'd1)
                                                            : (i_item.seq + 32'd1);
                            if (i_item.cls == sfra_pkg::CLS_DATA) begin
                                msg      = sum;
                                n.rbytes = '0;
                                n.fcount = '0;
                                n.ccount = '0;
                                v        = sfra_pkg::VERD_DONE;
                            end else begin
                                n.rbytes = sum;
                                n.fcount = fc1;
                                if (fc1 >= i_cfg.max_frag) begin
                                    fail_f = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        if (fault_f) begin
            if (i_cfg.dgram) begin
                v = sfra_pkg::VERD_DROP;
            end else begin
                fail_f = 1'b1;
            end
        end
        if (fail_f) begin
            v        = sfra_pkg::VERD_ERROR;
            n.rbytes = '0;
            n.fcount = '0;
            n.ccount = '0;
        end

        o_sess_n          = n;
        o_bitmap_n        = bm;
        o_res.verdict     = v;
        o_res.msg_len     = msg;
        o_res.plain_bytes = plain;
        o_res.up          = n.open;
        o_res.top         = n.hseq;
    end

endmodule

// File: rtl/core/secure_frame_receive_admission.sv
`timescale 1ns / 1ps

// Channel    | Direction | Handshake              | Contents
// -----------+-----------+------------------------+-------------------------------------
// s (input)  | in        | i_s_tvalid / o_s_tready | one received frame header per beat
// m (output) | out       | o_m_tvalid / i_m_tready | one verdict per frame header
// cfg        | in        | i_cfg_we (no wait)      | register index and write data
//
// One header is accepted in every cycle while the output side keeps up. From
// acceptance to its verdict a beat passes the input register, then the result
// register, with one pass through the window check and admission logic between.
// Reset is synchronous and active low; it restores the register defaults and
// closes the session. While the verdict register is full and not taken, the
// input register holds, and the input side stalls once it too is full.
module secure_frame_receive_admission #(
    parameter int WINDOW_BITS = sfra_pkg::WINDOW_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Frame header channel.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata, lowest bit up: sequence_number[31:0], payload_length[47:32],
    // parse_ok[48], auth_ok[49], zero fill [55:50].
    input  logic [sfra_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser, lowest bit up: operation[0], frame_class[3:1].
    input  logic [sfra_pkg::S_TUSER_W-1:0]   i_s_tuser,
    // Verdict channel.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata, lowest bit up: message_length[15:0], plain_length[31:16],
    // session_up[32], window_top[64:33], zero fill [71:65].
    output logic [sfra_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // tuser, lowest bit up: verdict[3:0].
    output logic [sfra_pkg::M_TUSER_W-1:0]   o_m_tuser,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [sfra_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfra_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    sfra_pkg::t_cfg         r_cfg;
    sfra_pkg::t_sess        r_sess;
    sfra_pkg::t_sess        n_sess;
    logic [WINDOW_BITS-1:0] r_bitmap;
    logic [WINDOW_BITS-1:0] n_bitmap;
    logic                   r_in_valid;
    sfra_pkg::t_item        r_in;
    logic                   r_out_valid;
    sfra_pkg::t_res         r_out;
    sfra_pkg::t_res         n_out;
    sfra_pkg::t_item        w_item;
    logic                   w_advance;
    logic                   w_s_accept;

    // Unpack the incoming beat into header fields.
    assign w_item.op   = i_s_tuser[0];
    assign w_item.cls  = i_s_tuser[3:1];
    assign w_item.seq  = i_s_tdata[31:0];
    assign w_item.plen = i_s_tdata[47:32];
    assign w_item.pok  = i_s_tdata[48];
    assign w_item.aok  = i_s_tdata[49];

    // The held header is decided, and the session state updated, in the cycle
    // it moves into the verdict register.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    sfra_judge #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_judge (
        .i_cfg     (r_cfg),
        .i_item    (r_in),
        .i_sess    (r_sess),
        .i_bitmap  (r_bitmap),
        .o_sess_n  (n_sess),
        .o_bitmap_n(n_bitmap),
        .o_res     (n_out)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dgram     <= sfra_pkg::RST_DGRAM;
            r_cfg.buf_limit <= sfra_pkg::RST_BUF_LIMIT;
            r_cfg.max_frag  <= sfra_pkg::RST_MAX_FRAG;
            r_cfg.max_ctrl  <= sfra_pkg::RST_MAX_CTRL;
        end else if (i_cfg_we) begin
            case (sfra_pkg::t_reg_idx'(i_cfg_idx))
                sfra_pkg::REG_DGRAM:     r_cfg.dgram     <= i_cfg_wdata[0];
                sfra_pkg::REG_BUF_LIMIT: r_cfg.buf_limit <= i_cfg_wdata;
                sfra_pkg::REG_MAX_FRAG:  r_cfg.max_frag  <= i_cfg_wdata[7:0];
                sfra_pkg::REG_MAX_CTRL:  r_cfg.max_ctrl  <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Session state, replay bitmap and the beat valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess      <= '0;
            r_bitmap    <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_sess   <= n_sess;
                r_bitmap <= n_bitmap;
            end
            if (w_s_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in <= w_item;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.verdict;
    assign o_m_tdata  = {7'd0, r_out.top, r_out.up, r_out.plain_bytes, r_out.msg_len};

endmodule
